// ===== design/vnf_pkg.sv =====
// Shared types and constants for the 2D value-noise fBm core.
`default_nettype none
package vnf_pkg;
    localparam int TABLE_SIZE_DEF      = 256;
    localparam int OCTAVES_DEF         = 3;
    localparam int COORD_FRAC_BITS_DEF = 12;

    localparam int COORD_W     = 24;
    localparam int ENTRY_W     = 8;
    localparam int NOISE_W     = 16;
    localparam int CELL_STAGES = 8;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 25;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [1:0] MODE_FBM    = 2'd1;
    localparam logic [1:0] MODE_RIDGED = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_FBM;

    typedef struct packed {
        logic                       req_type;
        logic [ENTRY_W-1:0]         idx;
        logic [ENTRY_W-1:0]         val;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_item;
endpackage
`default_nettype wire

// ===== design/value_noise_fbm_2d_core.sv =====
// Top level of the 2D value-noise fBm core: config register, octave cell chain, output skid.
//
// Input channel i_valid/o_ready carries load transactions (i_req_type 0: write
// i_table_value into permutation entry i_table_index) and sample transactions
// (i_req_type 1: noise at Q11.12 coordinates i_coord_x, i_coord_y). Only samples
// produce an output transaction on o_valid/i_ready with o_noise_value in Q0.16.
// Each octave cell keeps its own copies of the permutation table; a load walks
// the chain with the samples, so every sample sees exactly the loads before it.
// Throughput: one transaction per cycle while o_ready is high. The pipeline has eight
// stages per octave cell, three for normalization and one output register.
// i_cfg_wr_en writes noise_mode; write it only while the core is idle.
// Reset (synchronous, active low) clears all valid bits and sets noise_mode to fBm;
// table contents are undefined until loaded.
// When the receiver stalls, one more result parks in a skid register; o_ready
// then drops and the whole chain holds until the skid drains.
`default_nettype none
module value_noise_fbm_2d_core #(
    parameter int TABLE_SIZE      = vnf_pkg::TABLE_SIZE_DEF,
    parameter int OCTAVES         = vnf_pkg::OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = vnf_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_req_type,
    input  wire logic [vnf_pkg::ENTRY_W-1:0]         i_table_index,
    input  wire logic [vnf_pkg::ENTRY_W-1:0]         i_table_value,
    input  wire logic signed [vnf_pkg::COORD_W-1:0]  i_coord_x,
    input  wire logic signed [vnf_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [vnf_pkg::NOISE_W-1:0]              o_noise_value,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [1:0]                          i_cfg_wr_data
);
    localparam int SW = vnf_pkg::NOISE_W + OCTAVES;

    logic [1:0] r_noise_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_mode <= vnf_pkg::MODE_RESET;
        end else if (i_cfg_wr_en) begin
            r_noise_mode <= i_cfg_wr_data;
        end
    end

    logic r_skid_valid, r_out_valid;
    logic [15:0] r_skid_data, r_out_data;
    logic w_en, out_take;
    assign w_en     = !r_skid_valid;
    assign out_take = !r_out_valid || i_ready;

    vnf_pkg::t_item  w_item [OCTAVES+1];
    logic            w_vld  [OCTAVES+1];
    logic [SW-1:0]   w_sum  [OCTAVES+1];
    logic [15:0]     w_n0   [OCTAVES+1];

    assign w_item[0] = '{req_type: i_req_type, idx: i_table_index, val: i_table_value,
                         x: i_coord_x, y: i_coord_y};
    assign w_vld[0]  = i_valid;
    assign w_sum[0]  = '0;
    assign w_n0[0]   = '0;

    for (genvar g = 0; g < OCTAVES; g++) begin : g_cell
        vnf_cell #(
            .TABLE_SIZE (TABLE_SIZE),
            .OCTAVES    (OCTAVES),
            .FRAC       (COORD_FRAC_BITS),
            .OCT_IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_mode  (r_noise_mode),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .i_sum   (w_sum[g]),
            .i_n0    (w_n0[g]),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_item[g+1]),
            .o_sum   (w_sum[g+1]),
            .o_n0    (w_n0[g+1])
        );
    end

    logic        w_res_vld;
    logic [15:0] w_res;

    vnf_norm #(
        .OCTAVES (OCTAVES)
    ) u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_mode     (r_noise_mode),
        .i_vld      (w_vld[OCTAVES]),
        .i_req_type (w_item[OCTAVES].req_type),
        .i_sum      (w_sum[OCTAVES]),
        .i_n0       (w_n0[OCTAVES]),
        .o_vld      (w_res_vld),
        .o_noise    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_vld) begin
            if (out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_res_vld) begin
            if (out_take) begin
                r_out_data <= w_res;
            end else begin
                r_skid_data <= w_res;
            end
        end
    end

    assign o_ready       = w_en;
    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_data;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid filled without an output stall");

    a_mode_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_wr_en)) |-> $stable(r_noise_mode))
        else $error("noise mode changed without a write");
`endif
endmodule
`default_nettype wire

// ===== design/vnf_cell.sv =====
// One octave cell: table lookups, fade, bilinear lerp, optional ridge, weighted accumulate.
`default_nettype none
module vnf_cell #(
    parameter int TABLE_SIZE = vnf_pkg::TABLE_SIZE_DEF,
    parameter int OCTAVES    = vnf_pkg::OCTAVES_DEF,
    parameter int FRAC       = vnf_pkg::COORD_FRAC_BITS_DEF,
    parameter int OCT_IDX    = 0,
    localparam int SW        = vnf_pkg::NOISE_W + OCTAVES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [1:0]                   i_mode,
    input  wire logic                         i_vld,
    input  wire vnf_pkg::t_item               i_item,
    input  wire logic [SW-1:0]                i_sum,
    input  wire logic [vnf_pkg::NOISE_W-1:0]  i_n0,
    output logic                              o_vld,
    output vnf_pkg::t_item                    o_item,
    output logic [SW-1:0]                     o_sum,
    output logic [vnf_pkg::NOISE_W-1:0]       o_n0
);
    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int DEPTH = 1 << AW;
    localparam int XW    = vnf_pkg::COORD_W + OCTAVES + AW;
    localparam int NST   = vnf_pkg::CELL_STAGES;
    localparam int EW    = vnf_pkg::ENTRY_W;

    function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [16:0] f);
        logic signed [16:0] d;
        logic signed [35:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        s = $signed({4'b0, a, 16'b0}) + d * $signed({1'b0, f}) + 36'sd32768;
        return s[31:16];
    endfunction

    logic [EW-1:0] mem_a  [DEPTH];
    logic [EW-1:0] mem_b0 [DEPTH];
    logic [EW-1:0] mem_b1 [DEPTH];

    logic               r_vld  [NST];
    vnf_pkg::t_item     r_item [NST];
    logic [SW-1:0]      r_sum  [NST];
    logic [15:0]        r_n0   [NST];

    // lattice split
    logic signed [XW-1:0] xs, ys, xi, yi;
    logic [AW-1:0]        ix0, ix1, iy0;
    logic [15:0]          tx, ty;

    assign xs  = XW'($signed(i_item.x)) <<< OCT_IDX;
    assign ys  = XW'($signed(i_item.y)) <<< OCT_IDX;
    assign xi  = xs >>> FRAC;
    assign yi  = ys >>> FRAC;
    assign ix0 = xi[AW-1:0];
    assign ix1 = ix0 + AW'(1);
    assign iy0 = yi[AW-1:0];

    if (FRAC <= 16) begin : g_frac_up
        assign tx = 16'(32'(xs[FRAC-1:0]) << (16 - FRAC));
        assign ty = 16'(32'(ys[FRAC-1:0]) << (16 - FRAC));
    end else begin : g_frac_dn
        assign tx = xs[FRAC-1 -: 16];
        assign ty = ys[FRAC-1 -: 16];
    end

    logic we_a, we_b;
    assign we_a = i_vld && (i_item.req_type == vnf_pkg::REQ_LOAD)
               && ({24'b0, i_item.idx} < 32'(TABLE_SIZE));
    assign we_b = r_vld[0] && (r_item[0].req_type == vnf_pkg::REQ_LOAD)
               && ({24'b0, r_item[0].idx} < 32'(TABLE_SIZE));

    // stage A: first lookup
    logic [EW-1:0] r_a0, r_a1;
    logic [AW-1:0] r_iy;
    logic [15:0]   r_tx, r_ty;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (we_a) begin
                mem_a[AW'(i_item.idx)] <= i_item.val;
            end
            r_a0 <= mem_a[ix0];
            r_a1 <= mem_a[ix1];
            r_iy <= iy0;
            r_tx <= tx;
            r_ty <= ty;
        end
    end

    // stage B: second lookup, fade squares
    logic [AW-1:0] b0_lo, b0_hi, b1_lo, b1_hi;
    assign b0_lo = AW'(r_a0) + r_iy;
    assign b0_hi = b0_lo + AW'(1);
    assign b1_lo = AW'(r_a1) + r_iy;
    assign b1_hi = b1_lo + AW'(1);

    logic [EW-1:0] r_b00, r_b01, r_b10, r_b11;
    logic [31:0]   r_ttx, r_tty;
    logic [17:0]   r_kx, r_ky;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (we_b) begin
                mem_b0[AW'(r_item[0].idx)] <= r_item[0].val;
                mem_b1[AW'(r_item[0].idx)] <= r_item[0].val;
            end
            r_b00 <= mem_b0[b0_lo];
            r_b01 <= mem_b0[b0_hi];
            r_b10 <= mem_b1[b1_lo];
            r_b11 <= mem_b1[b1_hi];
            r_ttx <= 32'(r_tx) * 32'(r_tx);
            r_tty <= 32'(r_ty) * 32'(r_ty);
            r_kx  <= 18'd196608 - {1'b0, r_tx, 1'b0};
            r_ky  <= 18'd196608 - {1'b0, r_ty, 1'b0};
        end
    end

    // stage C: fade
    logic [49:0] px, py;
    assign px = 50'(r_ttx) * 50'(r_kx);
    assign py = 50'(r_tty) * 50'(r_ky);

    logic [16:0]   r_fx, r_fy;
    logic [EW-1:0] r_c00, r_c01, r_c10, r_c11;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx  <= 17'((px + 50'd2147483648) >> 32);
            r_fy  <= 17'((py + 50'd2147483648) >> 32);
            r_c00 <= r_b00;
            r_c01 <= r_b01;
            r_c10 <= r_b10;
            r_c11 <= r_b11;
        end
    end

    // stage D/E: lerp in x, then y
    logic [15:0] r_la, r_lb, r_n;
    logic [16:0] r_fy_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la   <= lerp({r_c00, r_c00}, {r_c10, r_c10}, r_fx);
            r_lb   <= lerp({r_c01, r_c01}, {r_c11, r_c11}, r_fx);
            r_fy_d <= r_fy;
            r_n    <= lerp(r_la, r_lb, r_fy_d);
        end
    end

    // stage F/G: ridge square and divide by 65535, rounded
    logic [15:0] ridge_r;
    assign ridge_r = r_n[15] ? 16'(17'd131070 - {r_n, 1'b0}) : {r_n[14:0], 1'b0};

    logic [31:0] r_rr;
    logic [15:0] r_n_f, r_n_g, r_nsel;
    logic [33:0] rr_nn, rr_q;
    assign rr_nn = 34'(r_rr) + 34'd32767;
    assign rr_q  = (rr_nn + (rr_nn >> 16) + 34'd1) >> 16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr   <= 32'(ridge_r) * 32'(ridge_r);
            r_n_f  <= r_n;
            r_n_g  <= r_n_f;
            r_nsel <= (i_mode == vnf_pkg::MODE_RIDGED) ? rr_q[15:0] : r_n_f;
        end
    end

    // stage H: accumulate
    logic [SW-1:0] n_sum;
    logic [15:0]   n_n0;
    assign n_sum = r_sum[NST-2] + (SW'(r_nsel) << (OCTAVES - 1 - OCT_IDX));
    assign n_n0  = (OCT_IDX == 0) ? r_n_g : r_n0[NST-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            r_sum[0]  <= i_sum;
            r_n0[0]   <= i_n0;
            for (int k = 1; k < NST - 1; k++) begin
                r_item[k] <= r_item[k-1];
                r_sum[k]  <= r_sum[k-1];
                r_n0[k]   <= r_n0[k-1];
            end
            r_item[NST-1] <= r_item[NST-2];
            r_sum[NST-1]  <= n_sum;
            r_n0[NST-1]   <= n_n0;
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_item = r_item[NST-1];
    assign o_sum  = r_sum[NST-1];
    assign o_n0   = r_n0[NST-1];
endmodule
`default_nettype wire

// ===== design/vnf_norm.sv =====
// Octave-sum normalization by reciprocal multiply, saturation and mode select.
`default_nettype none
module vnf_norm #(
    parameter int OCTAVES = vnf_pkg::OCTAVES_DEF,
    localparam int SW     = vnf_pkg::NOISE_W + OCTAVES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [1:0]                   i_mode,
    input  wire logic                         i_vld,
    input  wire logic                         i_req_type,
    input  wire logic [SW-1:0]                i_sum,
    input  wire logic [vnf_pkg::NOISE_W-1:0]  i_n0,
    output logic                              o_vld,
    output logic [vnf_pkg::NOISE_W-1:0]       o_noise
);
    localparam int NORM  = (1 << OCTAVES) - 1;
    localparam int RS    = vnf_pkg::RECIP_SHIFT;
    localparam int MW    = vnf_pkg::RECIP_W;
    localparam int RECIP = (1 << RS) / NORM;
    localparam int PW    = SW + MW;

    logic          r_vld1, r_vld2, r_vld3;
    logic [SW-1:0] r_nn1, r_nn2;
    logic [15:0]   r_n01, r_n02, r_res;
    logic [PW-1:0] r_prod;

    logic [SW-1:0] q0, rem, q;
    logic [15:0]   sat, res;
    assign q0  = SW'(r_prod >> RS);
    assign rem = r_nn2 - SW'(q0 * NORM);
    assign q   = (rem >= SW'(NORM)) ? q0 + SW'(1) : q0;
    assign sat = (q > SW'(16'hFFFF)) ? 16'hFFFF : q[15:0];
    assign res = ((i_mode == vnf_pkg::MODE_FBM) || (i_mode == vnf_pkg::MODE_RIDGED))
               ? sat : r_n02;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld && (i_req_type == vnf_pkg::REQ_SAMPLE);
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nn1  <= i_sum + SW'(NORM / 2);
            r_n01  <= i_n0;
            r_prod <= PW'(r_nn1) * PW'(RECIP);
            r_nn2  <= r_nn1;
            r_n02  <= r_n01;
            r_res  <= res;
        end
    end

    assign o_vld   = r_vld3;
    assign o_noise = r_res;
endmodule
`default_nettype wire

// ===== tb/sv/tb_value_noise_fbm_2d_core.sv =====
// Testbench for value_noise_fbm_2d_core: table loads, sampled noise checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_value_noise_fbm_2d_core;

    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;

    class noise_scoreboard;
        byte unsigned perm[256];
        logic [1:0]   mode;
        bit [15:0]    expected_q[$];
        int           errors;
        int           checked;

        function new();
            mode = vnf_pkg::MODE_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function longint fade(longint t);
            return (t * t * (196608 - 2 * t) + (longint'(1) << 31)) >> 32;
        endfunction

        function longint lattice_val(longint ix, longint iy);
            longint a;
            a = perm[int'(ix & 255)];
            return longint'(perm[int'((a + iy) & 255)]) * 257;
        endfunction

        function longint lerp(longint a, longint b, longint f);
            return (a * (65536 - f) + b * f + 32768) >> 16;
        endfunction

        function longint octave_val(longint x, longint y);
            longint ix, iy, fx, fy, a, b;
            ix = x >>> vnf_pkg::COORD_FRAC_BITS_DEF;
            iy = y >>> vnf_pkg::COORD_FRAC_BITS_DEF;
            fx = fade((x & 4095) << (16 - vnf_pkg::COORD_FRAC_BITS_DEF));
            fy = fade((y & 4095) << (16 - vnf_pkg::COORD_FRAC_BITS_DEF));
            a = lerp(lattice_val(ix, iy), lattice_val(ix + 1, iy), fx);
            b = lerp(lattice_val(ix, iy + 1), lattice_val(ix + 1, iy + 1), fx);
            return lerp(a, b, fy);
        endfunction

        function longint ridge(longint n);
            longint d, r;
            d = 2 * n - 65535;
            r = 65535 - (d < 0 ? -d : d);
            return (r * r + 32767) / 65535;
        endfunction

        function bit [15:0] predict_noise(longint x, longint y);
            longint sum, n;
            if (mode != vnf_pkg::MODE_FBM && mode != vnf_pkg::MODE_RIDGED)
                return 16'(octave_val(x, y));
            sum = 0;
            for (int o = 0; o < vnf_pkg::OCTAVES_DEF; o++) begin
                n = octave_val(x << o, y << o);
                if (mode == vnf_pkg::MODE_RIDGED) n = ridge(n);
                sum += n << (vnf_pkg::OCTAVES_DEF - 1 - o);
            end
            sum = (sum + 3) / 7;
            return sum > 65535 ? 16'hFFFF : 16'(sum);
        endfunction

        function void note_item(logic req, logic [7:0] idx, logic [7:0] val,
                                logic signed [23:0] x, logic signed [23:0] y);
            if (req == vnf_pkg::REQ_LOAD) perm[idx] = val;
            else expected_q.insert(expected_q.size(),
                                   predict_noise(longint'(x), longint'(y)));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(logic [15:0] v);
            bit [15:0] e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected noise_value %0d", v));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (v !== e) report_mismatch($sformatf("noise_value got %0d exp %0d", v, e));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_req_type = vnf_pkg::REQ_LOAD;
    logic [vnf_pkg::ENTRY_W-1:0] i_table_index = '0;
    logic [vnf_pkg::ENTRY_W-1:0] i_table_value = '0;
    logic signed [vnf_pkg::COORD_W-1:0] i_coord_x = '0;
    logic signed [vnf_pkg::COORD_W-1:0] i_coord_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [vnf_pkg::NOISE_W-1:0] o_noise_value;
    logic i_cfg_wr_en = 1'b0;
    logic [1:0] i_cfg_wr_data = '0;

    noise_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int n_loads = 0;
    int n_samples = 0;

    always #1 i_clk = ~i_clk;

    value_noise_fbm_2d_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_table_index(i_table_index),
        .i_table_value(i_table_value), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .o_valid(o_valid), .i_ready(i_ready), .o_noise_value(o_noise_value),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_noise_value);
    end

    task send_item(logic req, logic [7:0] idx, logic [7:0] val,
                   logic signed [23:0] x, logic signed [23:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_table_index <= idx;
        i_table_value <= val;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(req, idx, val, x, y);
        if (req == vnf_pkg::REQ_LOAD) n_loads++;
        else n_samples++;
    endtask

    task sample(logic signed [23:0] x, logic signed [23:0] y);
        send_item(vnf_pkg::REQ_SAMPLE, 8'($urandom), 8'($urandom), x, y);
    endtask

    task send_random();
        logic signed [23:0] x, y;
        if ($urandom_range(9) == 0) begin
            send_item(vnf_pkg::REQ_LOAD, 8'($urandom), 8'($urandom),
                      24'($urandom), 24'($urandom));
        end else begin
            if ($urandom_range(1)) begin
                x = 24'($urandom);
                y = 24'($urandom);
            end else begin
                x = 24'($urandom_range(131071)) - 24'sd65536;
                y = 24'($urandom_range(131071)) - 24'sd65536;
            end
            sample(x, y);
        end
    endtask

    task wait_idle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_mode(logic [1:0] m);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.mode = m;
        @(posedge i_clk);
    endtask

    task run_phase(logic [1:0] m, int idle, int stall, int count, bit hold, bit pause);
        write_mode(m);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        if (hold) hold_cycles = 300;
        for (int k = 0; k < count; k++) begin
            if (pause && k == count / 2) begin
                i_valid <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge i_clk);
            end
            send_random();
        end
    endtask

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 256; k++) begin
            send_item(vnf_pkg::REQ_LOAD, 8'(k), 8'($urandom), '0, '0);
        end

        // directed, reset mode (fBm)
        sample(24'sd0, 24'sd0);
        sample(24'sh7FFFFF, 24'sh7FFFFF);
        sample(-24'sd8388608, -24'sd8388608);
        sample(24'sh7FFFFF, -24'sd8388608);
        sample(-24'sd1, -24'sd1);
        sample(24'sh000FFF, 24'sh000800);
        sample(24'sh001000, -24'sd4096);
        send_item(vnf_pkg::REQ_LOAD, 8'd0, 8'hFF, '0, '0);
        send_item(vnf_pkg::REQ_LOAD, 8'd255, 8'h00, '0, '0);
        sample(24'sd0, 24'sd0);
        sample(-24'sd2048, 24'sd2048);
        wait_idle();
        foreach (sb.perm[k]) begin
            if (k < 8) send_item(vnf_pkg::REQ_LOAD, 8'(k), (k % 2) ? 8'hFF : 8'h00, '0, '0);
        end
        write_mode(MODE_SINGLE);
        sample(24'sh000800, 24'sh000800);
        sample(24'sh7FFFFF, 24'sd0);
        write_mode(vnf_pkg::MODE_RIDGED);
        sample(24'sh000800, 24'sh000800);
        sample(24'sd0, 24'sd0);
        write_mode(MODE_UNUSED);
        sample(24'sh000800, 24'sh000800);
        sample(-24'sd8388608, 24'sh7FFFFF);

        run_phase(MODE_SINGLE, 0, 0, 180, 1'b0, 1'b0);
        run_phase(vnf_pkg::MODE_FBM, 78, 0, 180, 1'b0, 1'b1);
        run_phase(vnf_pkg::MODE_RIDGED, 0, 78, 180, 1'b0, 1'b0);
        run_phase(MODE_UNUSED, 32, 32, 160, 1'b0, 1'b0);
        run_phase(vnf_pkg::MODE_RIDGED, 0, 0, 160, 1'b1, 1'b0);
        run_phase(vnf_pkg::MODE_FBM, 32, 32, 160, 1'b0, 1'b0);
        wait_idle();

        $display("Covered %0d table loads and %0d samples (%0d checked) in all four modes,",
                 n_loads, n_samples, sb.checked);
        $display("with sender gaps, receiver stalls and a long output hold-off.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
